// File: src/gbc_pkg.sv
// Shared types, register indexes and reset values for the button gesture classifier.
`timescale 1ns / 1ps

package gbc_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_LONG_PRESS     = 3'd0;
	localparam logic [IDX_W-1:0] REG_SINGLE_MAX     = 3'd1;
	localparam logic [IDX_W-1:0] REG_SINGLE_MIN     = 3'd2;
	localparam logic [IDX_W-1:0] REG_DOUBLE_GAP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_DOUBLE_HOLDOFF = 3'd4;

	// Register values after reset.
	localparam logic [CFG_W-1:0] LONG_PRESS_RST     = 16'd1000;
	localparam logic [CFG_W-1:0] SINGLE_MAX_RST     = 16'd500;
	localparam logic [CFG_W-1:0] SINGLE_MIN_RST     = 16'd20;
	localparam logic [CFG_W-1:0] DOUBLE_GAP_RST     = 16'd500;
	localparam logic [CFG_W-1:0] DOUBLE_HOLDOFF_RST = 16'd1000;

	typedef struct packed {
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] single_max_ms;
		logic [CFG_W-1:0] single_min_ms;
		logic [CFG_W-1:0] double_gap_ms;
		logic [CFG_W-1:0] double_holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic              prev_level;
		logic [TIME_W-1:0] press_time;
		logic [TIME_W-1:0] release_time;
		logic [TIME_W-1:0] single_time;
		logic [TIME_W-1:0] double_time;
		logic              prev_long;
	} state_t;

	typedef struct packed {
		logic              pressed_level;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic              level;
		logic              press_edge;
		logic              release_edge;
		logic              long_event;
		logic              single_event;
		logic              double_event;
		logic [TIME_W-1:0] down_time;
		logic [TIME_W-1:0] up_time;
	} result_t;

endpackage

// File: src/gbc_cfg.sv
// Configuration registers of the button gesture classifier.
`timescale 1ns / 1ps

module gbc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [gbc_pkg::IDX_W-1:0] cfg_index,
	input  logic [gbc_pkg::CFG_W-1:0] cfg_data,
	output gbc_pkg::cfg_t             cfg
);

	gbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms     <= gbc_pkg::LONG_PRESS_RST;
			cfg_q.single_max_ms     <= gbc_pkg::SINGLE_MAX_RST;
			cfg_q.single_min_ms     <= gbc_pkg::SINGLE_MIN_RST;
			cfg_q.double_gap_ms     <= gbc_pkg::DOUBLE_GAP_RST;
			cfg_q.double_holdoff_ms <= gbc_pkg::DOUBLE_HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbc_pkg::REG_LONG_PRESS:     cfg_q.long_press_ms     <= cfg_data;
				gbc_pkg::REG_SINGLE_MAX:     cfg_q.single_max_ms     <= cfg_data;
				gbc_pkg::REG_SINGLE_MIN:     cfg_q.single_min_ms     <= cfg_data;
				gbc_pkg::REG_DOUBLE_GAP:     cfg_q.double_gap_ms     <= cfg_data;
				gbc_pkg::REG_DOUBLE_HOLDOFF: cfg_q.double_holdoff_ms <= cfg_data;
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/gbc_core.sv
// Combinational classification of one sample against the gesture state.
`timescale 1ns / 1ps

module gbc_core (
	input  gbc_pkg::cfg_t    cfg,
	input  gbc_pkg::state_t  state,
	input  gbc_pkg::sample_t sample,
	output gbc_pkg::result_t result,
	output gbc_pkg::state_t  state_next
);

	logic                       lvl;
	logic [gbc_pkg::TIME_W-1:0] now;
	logic                       down;
	logic                       up;
	logic [gbc_pkg::TIME_W-1:0] press_time_n;
	logic [gbc_pkg::TIME_W-1:0] held;
	logic [gbc_pkg::TIME_W-1:0] since_single;
	logic [gbc_pkg::TIME_W-1:0] since_double;
	logic [gbc_pkg::TIME_W-1:0] long_lim;
	logic [gbc_pkg::TIME_W-1:0] max_lim;
	logic [gbc_pkg::TIME_W-1:0] min_lim;
	logic [gbc_pkg::TIME_W-1:0] gap_lim;
	logic [gbc_pkg::TIME_W-1:0] holdoff_lim;
	logic                       is_long;
	logic                       is_single;
	logic                       is_double;

	assign lvl  = sample.pressed_level;
	assign now  = sample.now_ms;
	assign down = lvl && !state.prev_level;
	assign up   = !lvl && state.prev_level;

	assign long_lim    = {{(gbc_pkg::TIME_W-gbc_pkg::CFG_W){1'b0}}, cfg.long_press_ms};
	assign max_lim     = {{(gbc_pkg::TIME_W-gbc_pkg::CFG_W){1'b0}}, cfg.single_max_ms};
	assign min_lim     = {{(gbc_pkg::TIME_W-gbc_pkg::CFG_W){1'b0}}, cfg.single_min_ms};
	assign gap_lim     = {{(gbc_pkg::TIME_W-gbc_pkg::CFG_W){1'b0}}, cfg.double_gap_ms};
	assign holdoff_lim = {{(gbc_pkg::TIME_W-gbc_pkg::CFG_W){1'b0}}, cfg.double_holdoff_ms};

	assign press_time_n = down ? now : state.press_time;

	// While held this is the hold time so far; on the release sample the press
	// time is unchanged, so the same difference is the press duration.
	assign held         = now - press_time_n;
	assign since_single = now - state.single_time;
	assign since_double = now - state.double_time;

	assign is_long   = (lvl || up) && (held >= long_lim);
	assign is_single = up && (held < max_lim) && (held > min_lim);
	assign is_double = is_single && (since_single < gap_lim) && (since_double > holdoff_lim);

	always_comb begin
		state_next.prev_level   = lvl;
		state_next.press_time   = press_time_n;
		state_next.release_time = up ? now : state.release_time;
		state_next.single_time  = is_single ? now : state.single_time;
		state_next.double_time  = is_double ? now : state.double_time;
		state_next.prev_long    = is_long;

		result.level        = lvl;
		result.press_edge   = down;
		result.release_edge = up;
		result.long_event   = is_long && !state.prev_long;
		result.single_event = is_single;
		result.double_event = is_double;
		result.down_time    = state_next.press_time;
		result.up_time      = state_next.release_time;
	end

endmodule

// File: src/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, classifier, result register.
// Pipeline: a sample accepted into the input register is classified combinationally and its
// result is captured in the output register, which presents it on the master side.
// Throughput: one sample per cycle while the master side is ready; the gesture state is
// updated in the same cycle that a result enters the output register.
// Reset: arst_n clears both valid flags and the gesture state and loads register defaults.
`timescale 1ns / 1ps

module button_gesture_classifier (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata fields from bit 0 up: pressed_level [0], now_ms [32:1], zero fill [39:33].
	input  logic [39:0]               s_tdata,

	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata fields from bit 0 up: level [0], press_edge [1], release_edge [2],
	// long_event [3], single_event [4], double_event [5], down_time [37:6],
	// up_time [69:38], zero fill [71:70].
	output logic [71:0]               m_tdata,

	input  logic                      cfg_we,
	input  logic [gbc_pkg::IDX_W-1:0] cfg_index,
	input  logic [gbc_pkg::CFG_W-1:0] cfg_data
);

	gbc_pkg::cfg_t    cfg;
	gbc_pkg::state_t  state_q;
	gbc_pkg::state_t  state_next;
	gbc_pkg::sample_t sample_s1;
	gbc_pkg::result_t result;
	gbc_pkg::result_t result_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             out_load;
	logic             advance;
	logic             in_fire;

	gbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gbc_core u_core (
		.cfg        (cfg),
		.state      (state_q),
		.sample     (sample_s1),
		.result     (result),
		.state_next (state_next)
	);

	// The output register can take a new result when it is empty or its current
	// result leaves in this cycle. A sample in the input register moves on then,
	// and the input register refills in the same cycle; the slave side stalls only while a
	// sample waits in the input register behind a result the master side has not taken.
	assign out_load = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_load;
	assign s_tready = !valid_s1 || out_load;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1.pressed_level <= s_tdata[0];
			sample_s1.now_ms        <= s_tdata[32:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// The gesture state moves forward exactly once for each classified sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00,
	                   result_s2.up_time,
	                   result_s2.down_time,
	                   result_s2.double_event,
	                   result_s2.single_event,
	                   result_s2.long_event,
	                   result_s2.release_edge,
	                   result_s2.press_edge,
	                   result_s2.level};

	// Only one edge can occur on a sample.
	a_one_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_s2.press_edge && result_s2.release_edge))
		else $error("press and release edge on the same result");

	// A single press is only ever reported on a release.
	a_single_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.single_event |-> result_s2.release_edge)
		else $error("single press without release edge");

	// A double press is a qualified single press.
	a_double_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.double_event |-> result_s2.single_event)
		else $error("double press without single press");

	// The stored level follows the sample that was just classified.
	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> state_q.prev_level == $past(sample_s1.pressed_level))
		else $error("stored level does not follow classified sample");

endmodule

// File: tb/tb.sv
// Self-checking stream testbench for the button gesture classifier.
`timescale 1ns / 1ps

module tb;

	typedef logic [gbc_pkg::CFG_W-1:0] thr_t;
	typedef logic [gbc_pkg::IDX_W-1:0] idx_t;

	// One queued sample. Rows whose result is obvious carry it typed in (known = 1).
	typedef struct packed {
		logic                       lvl;
		logic [gbc_pkg::TIME_W-1:0] now;
		logic                       known;
		gbc_pkg::result_t           want;
	} sample_item_t;

	// Directed table row: flags are {level, press, release, long, single, double}.
	typedef struct packed {
		logic                       lvl;
		logic [gbc_pkg::TIME_W-1:0] now;
		logic                       known;
		logic [5:0]                 flags;
		logic [gbc_pkg::TIME_W-1:0] down;
		logic [gbc_pkg::TIME_W-1:0] up;
	} gesture_row_t;

	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 225;
	localparam int PHASE_COUNT  = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_we = 1'b0;
	idx_t        cfg_index = gbc_pkg::REG_LONG_PRESS;
	thr_t        cfg_data = '0;

	button_gesture_classifier uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Our copy of the configuration registers, tracking every write on the port.
	thr_t thr_long    = gbc_pkg::LONG_PRESS_RST;
	thr_t thr_max     = gbc_pkg::SINGLE_MAX_RST;
	thr_t thr_min     = gbc_pkg::SINGLE_MIN_RST;
	thr_t thr_gap     = gbc_pkg::DOUBLE_GAP_RST;
	thr_t thr_holdoff = gbc_pkg::DOUBLE_HOLDOFF_RST;

	// Our copy of the gesture state.
	logic                       btn_level   = 1'b0;
	logic [gbc_pkg::TIME_W-1:0] btn_down_at = '0;
	logic [gbc_pkg::TIME_W-1:0] btn_up_at   = '0;
	logic [gbc_pkg::TIME_W-1:0] single_at   = '0;
	logic [gbc_pkg::TIME_W-1:0] double_at   = '0;
	logic                       was_long    = 1'b0;

	sample_item_t     sample_queue[$];
	gbc_pkg::result_t pending_results[$];

	// The transaction currently offered on the slave side and its typed-in result, if any.
	logic             cur_known = 1'b0;
	gbc_pkg::result_t cur_known_result = '0;

	int mismatches   = 0;
	int samples_seen = 0;
	int singles_seen = 0;
	int doubles_seen = 0;
	int longs_seen   = 0;
	int burst_left   = 1;
	int idle_cycles  = 0;
	logic [gbc_pkg::TIME_W-1:0] t_ms = '0;

	// Predicts the result of one sample and advances the gesture state.
	// Every time difference is a 32-bit subtraction, so it wraps like the hardware.
	function automatic gbc_pkg::result_t classify_sample(input logic lvl,
		input logic [gbc_pkg::TIME_W-1:0] now);
		gbc_pkg::result_t           r;
		logic                       down, up, is_long, is_single, is_double;
		logic [gbc_pkg::TIME_W-1:0] dur, held, since_single, since_double;
		dur  = '0;
		down = lvl && !btn_level;
		up   = !lvl && btn_level;
		if (down)
			btn_down_at = now;
		if (up) begin
			btn_up_at = now;
			dur = btn_up_at - btn_down_at;
		end
		btn_level = lvl;
		held = now - btn_down_at;
		// The long condition is live while held, judged by the duration on release,
		// and cleared while the button rests.
		if (lvl)
			is_long = held >= {16'd0, thr_long};
		else if (up)
			is_long = dur >= {16'd0, thr_long};
		else
			is_long = 1'b0;
		is_single = up && dur < {16'd0, thr_max} && dur > {16'd0, thr_min};
		// The double test sees the single and double times from before this sample.
		since_single = now - single_at;
		since_double = now - double_at;
		is_double = is_single && since_single < {16'd0, thr_gap}
			&& since_double > {16'd0, thr_holdoff};
		if (is_double)
			double_at = now;
		if (is_single)
			single_at = now;
		r.level        = lvl;
		r.press_edge   = down;
		r.release_edge = up;
		r.long_event   = is_long && !was_long;
		r.single_event = is_single;
		r.double_event = is_double;
		r.down_time    = btn_down_at;
		r.up_time      = btn_up_at;
		was_long = is_long;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: results are checked before the accepted sample is predicted, so a
	// result can never be matched against an expectation pushed at the same edge.
	always @(posedge clk) begin
		gbc_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting: %0h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("level", 32'(want.level), 32'(m_tdata[0]));
				check_field("press_edge", 32'(want.press_edge), 32'(m_tdata[1]));
				check_field("release_edge", 32'(want.release_edge), 32'(m_tdata[2]));
				check_field("long_event", 32'(want.long_event), 32'(m_tdata[3]));
				check_field("single_event", 32'(want.single_event), 32'(m_tdata[4]));
				check_field("double_event", 32'(want.double_event), 32'(m_tdata[5]));
				check_field("down_time", want.down_time, m_tdata[37:6]);
				check_field("up_time", want.up_time, m_tdata[69:38]);
				singles_seen += int'(m_tdata[4]);
				doubles_seen += int'(m_tdata[5]);
				longs_seen   += int'(m_tdata[3]);
			end
		end
		if (s_tvalid && s_tready) begin
			want = classify_sample(s_tdata[0], s_tdata[32:1]);
			// Typed-in rows replace the prediction; the state still advances above.
			if (cur_known)
				want = cur_known_result;
			pending_results.push_back(want);
			samples_seen++;
		end
	end

	// Watchdog: too many cycles without a transaction on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a transaction", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver: alternates stretches of always-ready, random ready and full stall.
	int rdy_left = 0;
	int rdy_mode = 0;
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 2);
			rdy_left = (rdy_mode == 2) ? $urandom_range(1, 25) : $urandom_range(5, 60);
		end else begin
			rdy_left--;
		end
		case (rdy_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				m_tready <= 1'b0;
			end
		endcase
	end

	task automatic push_sample(input logic lvl, input logic [gbc_pkg::TIME_W-1:0] now);
		sample_item_t it;
		it.lvl   = lvl;
		it.now   = now;
		it.known = 1'b0;
		it.want  = '0;
		sample_queue.push_back(it);
	endtask

	// Sender: offers the queued samples in bursts of random length with random gaps.
	task automatic play_samples();
		sample_item_t it;
		int           gap;
		while (sample_queue.size() != 0) begin
			it = sample_queue.pop_front();
			s_tvalid         <= 1'b1;
			s_tdata          <= {7'd0, it.now, it.lvl};
			cur_known        <= it.known;
			cur_known_result <= it.want;
			do @(posedge clk); while (!s_tready);
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 30);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// One edge first, so the expectation of the last accepted sample is queued.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input idx_t idx, input thr_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			gbc_pkg::REG_LONG_PRESS: begin
				thr_long = val;
			end
			gbc_pkg::REG_SINGLE_MAX: begin
				thr_max = val;
			end
			gbc_pkg::REG_SINGLE_MIN: begin
				thr_min = val;
			end
			gbc_pkg::REG_DOUBLE_GAP: begin
				thr_gap = val;
			end
			gbc_pkg::REG_DOUBLE_HOLDOFF: begin
				thr_holdoff = val;
			end
			default: begin
			end
		endcase
	endtask

	// Writes all five thresholds plus one write to an unused index, which must be ignored.
	task automatic write_thresholds(input thr_t lp, input thr_t mx, input thr_t mn,
		input thr_t gp, input thr_t ho);
		idx_t unused_idx;
		unused_idx = gbc_pkg::REG_DOUBLE_HOLDOFF + idx_t'($urandom_range(1, 3));
		write_reg(gbc_pkg::REG_LONG_PRESS, lp);
		write_reg(gbc_pkg::REG_SINGLE_MAX, mx);
		write_reg(unused_idx, thr_t'($urandom()));
		write_reg(gbc_pkg::REG_SINGLE_MIN, mn);
		write_reg(gbc_pkg::REG_DOUBLE_GAP, gp);
		write_reg(gbc_pkg::REG_DOUBLE_HOLDOFF, ho);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [gbc_pkg::TIME_W-1:0] near(input logic [gbc_pkg::TIME_W-1:0] v);
		return v + $urandom_range(0, 4) - 2;
	endfunction

	// Hold durations cluster around the thresholds so each comparison flips both ways.
	function automatic logic [gbc_pkg::TIME_W-1:0] pick_duration();
		case ($urandom_range(0, 5))
			0: return near({16'd0, thr_min});
			1: return near({16'd0, thr_max});
			2: return near({16'd0, thr_long});
			3: return $urandom_range(0, 600);
			4: return $urandom_range(0, 3000);
			default: return $urandom_range(0, 140000);
		endcase
	endfunction

	// Release-to-release spacing, aimed at the double gap and the holdoff.
	function automatic logic [gbc_pkg::TIME_W-1:0] pick_spacing();
		case ($urandom_range(0, 4))
			0, 1: return near({16'd0, thr_gap});
			2: return near({16'd0, thr_holdoff});
			3: return $urandom_range(0, 1500);
			default: return $urandom_range(0, 100000);
		endcase
	endfunction

	// Mostly well-formed press/hold/release gestures with random timing, plus some noise:
	// random levels at any 32-bit time or shortly after the current time.
	task automatic build_gestures(input int count);
		logic [gbc_pkg::TIME_W-1:0] dur, spacing, press_at;
		int                         target;
		target = sample_queue.size() + count;
		while (sample_queue.size() < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1))
						push_sample(1'($urandom_range(0, 1)), $urandom());
					else
						push_sample(1'($urandom_range(0, 1)), t_ms + $urandom_range(0, 50));
				end
			end else begin
				dur = pick_duration();
				spacing = pick_spacing();
				if ($urandom_range(0, 40) == 0)
					t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				t_ms += (spacing > dur) ? spacing - dur : $urandom_range(1, 50);
				press_at = t_ms;
				push_sample(1'b1, press_at);
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 1))
						push_sample(1'b1, press_at + near({16'd0, thr_long}));
					else
						push_sample(1'b1, press_at + $urandom_range(0, dur));
				end
				t_ms = press_at + dur;
				push_sample(1'b0, t_ms);
				repeat ($urandom_range(0, 2)) begin
					t_ms += $urandom_range(1, 100);
					push_sample(1'b0, t_ms);
				end
			end
		end
	endtask

	// Directed rows under the reset thresholds (long 1000, single window 20..500,
	// gap 500, holdoff 1000): a long hold with its one-shot event, a single press,
	// a double press, a second single blocked by the holdoff, bounce and over-long
	// presses at the window edges, and presses that straddle the time wrap.
	gesture_row_t directed_rows [22] = '{
		'{1'b0, 32'd0,          1'b1, 6'b000000, 32'd0,    32'd0},
		'{1'b1, 32'd100,        1'b1, 6'b110000, 32'd100,  32'd0},
		'{1'b1, 32'd1100,       1'b1, 6'b100100, 32'd100,  32'd0},
		'{1'b1, 32'd1200,       1'b1, 6'b100000, 32'd100,  32'd0},
		'{1'b0, 32'd1300,       1'b1, 6'b001000, 32'd100,  32'd1300},
		'{1'b0, 32'd1400,       1'b1, 6'b000000, 32'd100,  32'd1300},
		'{1'b1, 32'd2000,       1'b1, 6'b110000, 32'd2000, 32'd1300},
		'{1'b0, 32'd2100,       1'b1, 6'b001010, 32'd2000, 32'd2100},
		'{1'b1, 32'd2200,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'd2300,       1'b1, 6'b001011, 32'd2200, 32'd2300},
		'{1'b1, 32'd2400,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'd2500,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b1, 32'd3000,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'd3020,       1'b1, 6'b001000, 32'd3000, 32'd3020},
		'{1'b1, 32'd4000,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'd4500,       1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b1, 32'hFFFF_FFF0,  1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'h0000_0040,  1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b1, 32'hFFFF_FFFF,  1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b1, 32'h0000_03E7,  1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'h0000_03E8,  1'b0, 6'b000000, 32'd0,    32'd0},
		'{1'b0, 32'h0000_2000,  1'b0, 6'b000000, 32'd0,    32'd0}
	};

	initial begin
		sample_item_t it;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			it.lvl   = directed_rows[i].lvl;
			it.now   = directed_rows[i].now;
			it.known = directed_rows[i].known;
			it.want  = {directed_rows[i].flags, directed_rows[i].down, directed_rows[i].up};
			sample_queue.push_back(it);
		end
		play_samples();
		wait_drained();
		t_ms = 32'h0000_4000;

		// Threshold settings: all zero, all ones, reset values again, then random.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					write_thresholds('0, '0, '0, '0, '0);
				end
				1: begin
					write_thresholds('1, '1, '1, '1, '1);
				end
				2: begin
					write_thresholds(gbc_pkg::LONG_PRESS_RST, gbc_pkg::SINGLE_MAX_RST,
						gbc_pkg::SINGLE_MIN_RST, gbc_pkg::DOUBLE_GAP_RST,
						gbc_pkg::DOUBLE_HOLDOFF_RST);
				end
				PHASE_COUNT - 1: begin
					write_thresholds(thr_t'($urandom()), thr_t'($urandom()),
						thr_t'($urandom()), thr_t'($urandom()), thr_t'($urandom()));
				end
				default: begin
					write_thresholds(thr_t'($urandom_range(0, 3000)),
						thr_t'($urandom_range(0, 1500)), thr_t'($urandom_range(0, 120)),
						thr_t'($urandom_range(0, 1500)), thr_t'($urandom_range(0, 3000)));
				end
			endcase
			build_gestures(PHASE_ITEMS);
			play_samples();
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("covered %0d samples over %0d threshold settings", samples_seen,
			PHASE_COUNT + 1);
		$display("observed %0d single, %0d double and %0d long events", singles_seen,
			doubles_seen, longs_seen);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
